// ===== hw/rtl/wrench_ema_filter_with_tare_core_macros.svh =====
// ----------------------------------------------------------------------------
// wrench_ema_filter_with_tare_core_macros
// Assertion macros for the wrench EMA core checker.
// ----------------------------------------------------------------------------
`ifndef WRENCH_EMA_FILTER_WITH_TARE_CORE_MACROS_SVH
`define WRENCH_EMA_FILTER_WITH_TARE_CORE_MACROS_SVH
// implication checked every clock, off in reset
`define WEF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/wef_pkg.sv =====
// ----------------------------------------------------------------------------
// wef_pkg
// Shared types and constants of the wrench EMA filter with tare.
// ----------------------------------------------------------------------------
package wef_pkg;
  localparam int SampleBits    = 24;
  localparam int AlphaFracBits = 16;
  localparam int AgeBits       = 16;
  localparam int NumCh         = 6;
  localparam int ChIdxBits     = 3;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindTare   = 2'd1;
  localparam logic [1:0] KindTick   = 2'd2;

  localparam logic CfgAlpha  = 1'b0;
  localparam logic CfgMaxAge = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic                 load_in;   // capture input beat
    logic                 do_ema;    // update channel ch
    logic                 do_tare;   // copy filtered to bias
    logic                 do_tick;   // age step
    logic                 sq_step;   // accumulate square of channel ch
    logic                 sq_clr;
    logic                 rt_start;
    logic [ChIdxBits-1:0] ch;
    logic                 out_load;
  } wef_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rt_done;
  } wef_sts_t;
endpackage

// ===== hw/rtl/wef_ctrl.sv =====
// ----------------------------------------------------------------------------
// wef_ctrl
// Sequencer: EMA over six channels (samples only), squares of the three force
// channels, root, then output load.
module wef_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_busy_i,
  input  logic [1:0]        kind_i,
  output wef_pkg::wef_cmd_t cmd_o,
  input  wef_pkg::wef_sts_t sts_i
);
  import wef_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StEma, StSq, StRoot, StOut
  } state_e;

  state_e               state_q;
  logic [ChIdxBits-1:0] ch_q;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o          = '0;
    cmd_o.ch       = ch_q;
    cmd_o.load_in  = (state_q == StIdle) && in_valid_i;
    cmd_o.do_tare  = cmd_o.load_in && (kind_i == KindTare);
    cmd_o.do_tick  = cmd_o.load_in && (kind_i == KindTick);
    cmd_o.sq_clr   = cmd_o.load_in;
    cmd_o.do_ema   = (state_q == StEma);
    cmd_o.sq_step  = (state_q == StSq);
    cmd_o.rt_start = (state_q == StSq) && (ch_q == ChIdxBits'(2));
    cmd_o.out_load = (state_q == StOut) && !out_busy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          ch_q <= '0;
          if (in_valid_i) state_q <= (kind_i == KindSample) ? StEma : StSq;
        end
        StEma: begin
          if (ch_q == ChIdxBits'(NumCh - 1)) begin
            ch_q    <= '0;
            state_q <= StSq;
          end else ch_q <= ch_q + 1'b1;
        end
        StSq: begin
          if (ch_q == ChIdxBits'(2)) state_q <= StRoot;
          else ch_q <= ch_q + 1'b1;
        end
        StRoot: if (sts_i.rt_done) state_q <= StOut;
        StOut: if (!out_busy_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hw/rtl/wef_dpath.sv =====
// ----------------------------------------------------------------------------
// wef_dpath
// Channel stores, shared EMA multiplier, square accumulator, bit-pair root.
// ----------------------------------------------------------------------------
module wef_dpath #(
  parameter int SAMPLE_BITS     = wef_pkg::SampleBits,
  parameter int ALPHA_FRAC_BITS = wef_pkg::AlphaFracBits,
  parameter int AGE_BITS        = wef_pkg::AgeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wef_pkg::wef_cmd_t             cmd_i,
  output wef_pkg::wef_sts_t             sts_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_i [wef_pkg::NumCh],
  input  logic [ALPHA_FRAC_BITS:0]      alpha_i,
  input  logic [AGE_BITS-1:0]           max_age_i,
  output logic signed [SAMPLE_BITS:0]   comp_o [wef_pkg::NumCh],
  output logic [SAMPLE_BITS:0]          mag_o,
  output logic                          valid_o
);
  import wef_pkg::*;

  localparam int CW  = SAMPLE_BITS + 1;
  localparam int SQW = 2 * CW + 2;
  localparam int RW  = SQW / 2 + 1;
  localparam int RCW = $clog2(RW + 1);
  localparam int PW  = SAMPLE_BITS + ALPHA_FRAC_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] filt_q [NumCh];
  logic signed [SAMPLE_BITS-1:0] bias_q [NumCh];
  logic signed [SAMPLE_BITS-1:0] raw_q  [NumCh];
  logic [AGE_BITS-1:0]           age_q;
  logic                          seen_q;
  logic                          zero_q;
  logic [SQW-1:0]                sum_q;
  logic [SQW-1:0]                rem_q;
  logic [RW-1:0]                 res_q;
  logic [RCW-1:0]                cnt_q;
  logic                          rt_busy_q;
  logic [ALPHA_FRAC_BITS:0]      a_c;
  logic signed [PW-1:0]          prod;
  logic signed [CW-1:0]          csel;
  logic [CW-1:0]                 cmag;
  logic [SQW-1:0]                trial;
  logic [SQW-1:0]                rem_sh;
  logic [SQW-1:0]                sum_nx;
  logic [SQW-1:0]                sum_sat;
  logic                          all_zero;

  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < NumCh; i++) if (filt_q[i] != '0) all_zero = 1'b0;
  end

  assign a_c = (alpha_i > (1 << ALPHA_FRAC_BITS)) ?
               (ALPHA_FRAC_BITS+1)'(1 << ALPHA_FRAC_BITS) : alpha_i;
  // a*raw + (1-a)*prev = prev + a*(raw-prev): one multiply
  assign prod = PW'(signed'({1'b0, a_c})) *
                (PW'(raw_q[cmd_i.ch]) - PW'(filt_q[cmd_i.ch]));

  always_comb
    for (int i = 0; i < NumCh; i++) comp_o[i] = CW'(filt_q[i]) - CW'(bias_q[i]);

  assign csel  = comp_o[cmd_i.ch];
  assign cmag  = csel[CW-1] ? CW'(-csel) : CW'(csel);
  assign rem_sh = {rem_q[SQW-3:0], sum_q[SQW-1:SQW-2]};
  assign trial  = SQW'({res_q[RW-2:0], 2'b01});
  assign sum_nx = sum_q + SQW'(cmag * cmag);
  // sum of squares clamps at 64 ones before the root (wide samples only)
  assign sum_sat = (SQW > 64 && (sum_nx >> 64) != '0) ? SQW'({64{1'b1}}) : sum_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        filt_q[i] <= '0;
        bias_q[i] <= '0;
      end
      age_q     <= '0;
      seen_q    <= 1'b0;
      rt_busy_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.load_in && kind_i == KindSample) begin
        age_q  <= '0;
        seen_q <= 1'b1;
      end
      if (cmd_i.do_tick && age_q != '1) age_q <= age_q + 1'b1;
      if (cmd_i.do_tare) for (int i = 0; i < NumCh; i++) bias_q[i] <= filt_q[i];
      if (cmd_i.do_ema) begin
        if (zero_q) filt_q[cmd_i.ch] <= raw_q[cmd_i.ch];
        else filt_q[cmd_i.ch] <= filt_q[cmd_i.ch] + SAMPLE_BITS'(prod >>> ALPHA_FRAC_BITS);
      end
      if (cmd_i.rt_start) begin
        rt_busy_q <= 1'b1;
        cnt_q     <= RCW'(SQW / 2);
      end else if (rt_busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == RCW'(1)) rt_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < NumCh; i++) raw_q[i] <= raw_i[i];
      zero_q <= all_zero;
    end
    if (cmd_i.sq_clr) sum_q <= '0;
    else if (cmd_i.sq_step && !cmd_i.rt_start) sum_q <= sum_nx;
    if (cmd_i.rt_start) begin
      sum_q <= sum_sat;
      rem_q <= '0;
      res_q <= '0;
    end else if (rt_busy_q) begin
      sum_q <= {sum_q[SQW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        res_q <= {res_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        res_q <= {res_q[RW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.rt_done = rt_busy_q && (cnt_q == RCW'(1));
  assign mag_o   = CW'(res_q);
  assign valid_o = seen_q && (age_q < max_age_i);
endmodule

// ===== hw/rtl/wrench_ema_filter_with_tare_core.sv =====
// Flow: one item at a time; a new beat is taken only once the last result is
// loaded for output (bit-pair root loop, one result bit a cycle, plus the serial channel walk).
// Reset: rst_ni async low clears filtered, bias, age, seen flag, alpha to
// 13107 and max age to 1000.
// ----------------------------------------------------------------------------
// wrench_ema_filter_with_tare_core
// Six-channel EMA force/torque conditioner with tare and force magnitude.
// ----------------------------------------------------------------------------
module wrench_ema_filter_with_tare_core #(
  parameter int SAMPLE_BITS     = wef_pkg::SampleBits,
  parameter int ALPHA_FRAC_BITS = wef_pkg::AlphaFracBits,
  parameter int AGE_BITS        = wef_pkg::AgeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [SAMPLE_BITS-1:0] force_x_i,
  input  logic signed [SAMPLE_BITS-1:0] force_y_i,
  input  logic signed [SAMPLE_BITS-1:0] force_z_i,
  input  logic signed [SAMPLE_BITS-1:0] torque_x_i,
  input  logic signed [SAMPLE_BITS-1:0] torque_y_i,
  input  logic signed [SAMPLE_BITS-1:0] torque_z_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS:0]   comp_force_x_o,
  output logic signed [SAMPLE_BITS:0]   comp_force_y_o,
  output logic signed [SAMPLE_BITS:0]   comp_force_z_o,
  output logic signed [SAMPLE_BITS:0]   comp_torque_x_o,
  output logic signed [SAMPLE_BITS:0]   comp_torque_y_o,
  output logic signed [SAMPLE_BITS:0]   comp_torque_z_o,
  output logic [SAMPLE_BITS:0]          force_magnitude_o,
  output logic                          data_valid_o
);
  import wef_pkg::*;

  wef_cmd_t                      cmd;
  wef_sts_t                      sts;
  logic [ALPHA_FRAC_BITS:0]      alpha_q;
  logic [AGE_BITS-1:0]           max_age_q;
  logic signed [SAMPLE_BITS-1:0] raw [NumCh];
  logic signed [SAMPLE_BITS:0]   comp [NumCh];
  logic [SAMPLE_BITS:0]          mag;
  logic                          dv;
  logic                          out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign raw[0] = force_x_i;
  assign raw[1] = force_y_i;
  assign raw[2] = force_z_i;
  assign raw[3] = torque_x_i;
  assign raw[4] = torque_y_i;
  assign raw[5] = torque_z_i;

  // config registers; writes must arrive only while idle (the user's duty, the block does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= (ALPHA_FRAC_BITS+1)'(13107);
      max_age_q <= AGE_BITS'(1000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAlpha:  alpha_q   <= cfg_data_i[ALPHA_FRAC_BITS:0];
        CfgMaxAge: max_age_q <= AGE_BITS'(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  wef_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_q && out_stall_i),
    .kind_i, .cmd_o(cmd), .sts_i(sts)
  );

  wef_dpath #(
    .SAMPLE_BITS(SAMPLE_BITS), .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS), .AGE_BITS(AGE_BITS)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .raw_i(raw),
    .alpha_i(alpha_q), .max_age_i(max_age_q), .comp_o(comp), .mag_o(mag), .valid_o(dv)
  );

  // output register: result beat held until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      comp_force_x_o    <= comp[0];
      comp_force_y_o    <= comp[1];
      comp_force_z_o    <= comp[2];
      comp_torque_x_o   <= comp[3];
      comp_torque_y_o   <= comp[4];
      comp_torque_z_o   <= comp[5];
      force_magnitude_o <= mag;
      data_valid_o      <= dv;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== hw/rtl/wef_checker.sv =====
// ----------------------------------------------------------------------------
// wef_checker
// Port-level checks of the wrench EMA core, bound to the top level.
// ----------------------------------------------------------------------------
`include "wrench_ema_filter_with_tare_core_macros.svh"
module wef_checker #(
  parameter int SAMPLE_BITS = wef_pkg::SampleBits
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [SAMPLE_BITS:0] force_magnitude_o
);
  // accepted beat starts work: input stalls next cycle
  `WEF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // no result appears while idle and empty
  `WEF_ASSERT_NEXT(a_no_spurious_out, clk_i, rst_ni, !in_stall_o && !out_valid_o, !out_valid_o)
  // stalled result holds
  `WEF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(force_magnitude_o))
endmodule

bind wrench_ema_filter_with_tare_core wef_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .force_magnitude_o
);

// ===== dv/wrench_ema_filter_with_tare_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrench_ema_filter_with_tare_core_test
// Self-checking bench: a directed table of beats, then random beats, checked
// field by field against a wrench conditioner model or a row's literal value.
// ----------------------------------------------------------------------------
module wrench_ema_filter_with_tare_core_test;
  import wef_pkg::*;

  localparam int SB        = SampleBits;
  localparam int AlphaOne  = 1 << AlphaFracBits;
  localparam int KindSpare = 3;
  localparam int CycleCap  = 400000;
  localparam int DrainWait = 80;

  typedef logic signed [SB-1:0] raw_t;
  typedef logic signed [SB:0]   comp_t;

  typedef struct {
    comp_t       comp [6];
    logic [SB:0] mag;
    logic        ok;
  } wrench_t;

  // directed row: kind, raw channels, optional literal expectation
  typedef struct {
    logic [1:0] kind;
    raw_t       raw [6];
    logic       has_lit;
    wrench_t    lit;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = '0;
  raw_t force_x_i = '0, force_y_i = '0, force_z_i = '0;
  raw_t torque_x_i = '0, torque_y_i = '0, torque_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CfgAlpha;
  logic [31:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  comp_t comp_force_x_o, comp_force_y_o, comp_force_z_o;
  comp_t comp_torque_x_o, comp_torque_y_o, comp_torque_z_o;
  logic [SB:0] force_magnitude_o;
  logic data_valid_o;

  wrench_ema_filter_with_tare_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  longint filt [6];
  longint bias [6];
  longint age_cnt;
  bit     seen;
  longint alpha_reg;
  longint max_age;

  string comp_names [6] = '{"comp_force_x", "comp_force_y", "comp_force_z",
                            "comp_torque_x", "comp_torque_y", "comp_torque_z"};

  wrench_t pending_wrench [$];
  int  fails;
  int  cycles;
  int  idle_pct;     // sender/receiver idle percentage
  bit  hold_rx;      // long receiver hold-off request
  bit  lit_mode;     // current beat carries a literal expectation
  wrench_t lit_exp;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // advance the conditioner state by one beat and form its result
  function automatic wrench_t condition(logic [1:0] kind, raw_t raw [6]);
    wrench_t w;
    longint a, b, c;
    longint unsigned acc;
    bit zero;
    zero = 1;
    acc  = 0;
    if (kind == KindSample) begin
      a = (alpha_reg > AlphaOne) ? AlphaOne : alpha_reg;
      b = AlphaOne - a;
      foreach (filt[i]) if (filt[i] != 0) zero = 0;
      foreach (filt[i])
        filt[i] = zero ? longint'(raw[i]) : ((a * raw[i] + b * filt[i]) >>> AlphaFracBits);
      age_cnt = 0;
      seen = 1;
    end else if (kind == KindTare) begin
      foreach (filt[i]) bias[i] = filt[i];
    end else if (kind == KindTick) begin
      if (age_cnt < (1 << AgeBits) - 1) age_cnt++;
    end
    for (int i = 0; i < 6; i++) begin
      c = filt[i] - bias[i];
      w.comp[i] = comp_t'(c);
      if (i < 3) acc += longint'(c * c);
    end
    w.mag = (SB + 1)'(isqrt(acc));
    w.ok  = seen && (age_cnt < max_age);
    return w;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    wrench_t e;
    comp_t got [6];
    if (out_valid_o && !out_stall_i) begin
      got = '{comp_force_x_o, comp_force_y_o, comp_force_z_o,
              comp_torque_x_o, comp_torque_y_o, comp_torque_z_o};
      if (pending_wrench.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        e = pending_wrench.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== e.comp[i]) begin
            $error("%s: expected %0d, got %0d", comp_names[i], e.comp[i], got[i]);
            fails++;
          end
        if (force_magnitude_o !== e.mag) begin
          $error("force_magnitude: expected %0d, got %0d", e.mag, force_magnitude_o);
          fails++;
        end
        if (data_valid_o !== e.ok) begin
          $error("data_valid: expected %0b, got %0b", e.ok, data_valid_o);
          fails++;
        end
      end
    end
  end

  // ---------------- receiver stall ----------------
  always @(posedge clk_i) begin
    int hold;
    if (hold_rx) begin
      out_stall_i <= 1'b1;
      hold = 0;
      while (hold < 300) begin
        @(posedge clk_i);
        hold++;
      end
      out_stall_i <= 1'b0;
      hold_rx = 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // send one beat and wait for acceptance; expectation queued at acceptance
  task automatic send_beat(logic [1:0] kind, raw_t raw [6]);
    wrench_t w;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    force_x_i  <= raw[0];
    force_y_i  <= raw[1];
    force_z_i  <= raw[2];
    torque_x_i <= raw[3];
    torque_y_i <= raw[4];
    torque_z_i <= raw[5];
    do @(posedge clk_i); while (in_stall_o);
    w = condition(kind, raw);
    if (lit_mode && (w.comp != lit_exp.comp || w.mag != lit_exp.mag || w.ok != lit_exp.ok))
      w = lit_exp;  // literal row value wins; a mismatch exposes either side
    pending_wrench.push_back(w);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgAlpha) alpha_reg = val & ((1 << (AlphaFracBits + 1)) - 1);
    else max_age = val & 16'hFFFF;
    @(posedge clk_i);
  endtask

  // idle point for register writes: drain, then wait out any in-flight work
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_wrench.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic raw_t rnd_raw;
    case ($urandom_range(7))
      0: return raw_t'(-(1 << (SB - 1)));
      1: return raw_t'((1 << (SB - 1)) - 1);
      2: return raw_t'($urandom_range(2000) - 1000);
      default: return raw_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rnd_kind;
    int p = $urandom_range(99);
    if (p < 60) return KindSample;
    if (p < 72) return KindTare;
    if (p < 97) return KindTick;
    return 2'(KindSpare);
  endfunction

  localparam raw_t RMax = (1 << (SB - 1)) - 1;
  localparam raw_t RMin = -(1 << (SB - 1));

  row_t rows [$];

  function automatic row_t mk(logic [1:0] k, raw_t v0, raw_t v1, raw_t v2,
                              raw_t v3, raw_t v4, raw_t v5);
    row_t r;
    r.kind = k;
    r.raw = '{v0, v1, v2, v3, v4, v5};
    r.has_lit = 0;
    return r;
  endfunction

  initial begin
    row_t r;
    raw_t rr [6];
    wrench_t zero_w;
    fails = 0;
    cycles = 0;
    idle_pct = 35;
    hold_rx = 0;
    lit_mode = 0;
    foreach (filt[i]) begin
      filt[i] = 0;
      bias[i] = 0;
    end
    age_cnt = 0;
    seen = 0;
    alpha_reg = 13107;
    max_age = 1000;
    foreach (zero_w.comp[i]) zero_w.comp[i] = '0;
    zero_w.mag = '0;
    zero_w.ok = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset-state reads first, with literal expectations
    r = mk(KindTick, 0, 0, 0, 0, 0, 0); r.has_lit = 1; r.lit = zero_w; rows.push_back(r);
    r = mk(KindTare, 0, 0, 0, 0, 0, 0); r.has_lit = 1; r.lit = zero_w; rows.push_back(r);
    r = mk(2'(KindSpare), RMax, RMin, 1, -1, 5, 7); r.has_lit = 1; r.lit = zero_w;
    rows.push_back(r);
    // first sample loads raw directly (all filtered zero)
    rows.push_back(mk(KindSample, RMax, RMax, RMax, RMin, RMin, RMin));
    rows.push_back(mk(KindSample, RMin, RMin, RMin, RMax, RMax, RMax));
    rows.push_back(mk(KindTare, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(KindSample, RMax, RMin, RMax, -1, 0, 1));
    rows.push_back(mk(KindSample, -1, -1, -1, -1, -1, -1));
    rows.push_back(mk(KindTick, RMax, 0, 0, 0, 0, 0));
    rows.push_back(mk(2'(KindSpare), 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(KindSample, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(KindSample, 3, -3, 100, -100, 12345, -12345));

    foreach (rows[i]) begin
      lit_mode = rows[i].has_lit;
      lit_exp  = rows[i].lit;
      send_beat(rows[i].kind, rows[i].raw);
    end
    lit_mode = 0;

    // alpha above one clamps; alpha zero freezes the filter
    drain();
    write_reg(CfgAlpha, 32'h1FFFF);
    write_reg(CfgMaxAge, 0);  // zero limit: never valid
    repeat (4) begin
      foreach (rr[i]) rr[i] = rnd_raw();
      send_beat(KindSample, rr);
    end
    drain();
    write_reg(CfgAlpha, 0);
    write_reg(CfgMaxAge, 2);
    for (int i = 0; i < 6; i++) begin
      foreach (rr[j]) rr[j] = rnd_raw();
      send_beat(i % 2 ? KindTick : KindSample, rr);
    end

    // age ticks: a run of ticks with the widest limit (too few to saturate)
    drain();
    write_reg(CfgAlpha, AlphaOne);
    write_reg(CfgMaxAge, 16'hFFFF);
    idle_pct = 0;  // long stretch without idling
    repeat (40) send_beat(KindTick, rr);
    idle_pct = 35;

    // random phases with different settings
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CfgAlpha, ph == 4 ? AlphaOne : $urandom_range(AlphaOne + 50));
      write_reg(CfgMaxAge, ph == 0 ? 16'hFFFF : $urandom_range(30));
      if (ph == 2) hold_rx = 1;
      if (ph == 3) idle_pct = 0;
      else idle_pct = 35;
      repeat (125) begin
        foreach (rr[i]) rr[i] = rnd_raw();
        send_beat(rnd_kind(), rr);
      end
    end

    drain();
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wef_pkg.sv
hw/rtl/wef_ctrl.sv
hw/rtl/wef_dpath.sv
hw/rtl/wrench_ema_filter_with_tare_core.sv
hw/rtl/wef_checker.sv
dv/wrench_ema_filter_with_tare_core_test.sv
